// ----- rtl/pffra_pkg.sv -----
// shared types and constants of the preferred first-fit range allocator
package pffra_pkg;

  localparam int WANT_W = 32;
  localparam int LEN_W  = 25;
  localparam int UNIT_W = 34;
  localparam int CAND_W = UNIT_W + 1;

  typedef struct packed {
    logic [WANT_W-1:0] want_start;
    logic [LEN_W-1:0]  span_length;
  } pffra_req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] given_start;
    logic [UNIT_W-1:0] given_end;
    logic              rejected;
  } pffra_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_EVAL,
    ST_LOAD,
    ST_LOAD_WAIT,
    ST_FINISH
  } pffra_state_t;

  typedef enum logic [1:0] {
    PH_WANT,
    PH_ONE,
    PH_CAND
  } pffra_phase_t;

  typedef struct packed {
    logic load_req;
    logic set_one;
    logic clr_hit;
    logic rd_scan;
    logic rd_load;
    logic update;
    logic emit;
  } pffra_cmd_t;

  typedef struct packed {
    logic hit;
    logic found;
    logic res_free;
  } pffra_sts_t;

endpackage

// ----- rtl/pffra_stream_if.sv -----
// valid/ready stream interface carrying one payload per transaction
interface pffra_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/pffra_ctrl.sv -----
// controller: sequences candidate starts and table scans
module pffra_ctrl
  import pffra_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int IDX_W       = $clog2(MAX_ENTRIES),
  parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output pffra_cmd_t       cmd,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] wr_addr,
  input  pffra_sts_t       sts
);

  pffra_state_t     state, state_next;
  pffra_phase_t     phase, phase_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] k, k_next;
  logic [IDX_W-1:0] j, j_next;
  logic [IDX_W-1:0] last_idx;
  logic [CNT_W-1:0] count_m1;
  logic             full;

  assign count_m1 = count - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];
  assign full     = (count == CNT_W'(MAX_ENTRIES));
  assign wr_addr  = count[IDX_W-1:0];
  assign rd_addr  = (state == ST_LOAD) ? j : k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_WANT;
      count <= '0;
      k     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      count <= count_next;
      k     <= k_next;
      j     <= j_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    count_next = count;
    k_next     = k;
    j_next     = j;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          phase_next   = PH_WANT;
          k_next       = '0;
          if (full) begin
            state_next = ST_FINISH;
          end else if (count == '0) begin
            state_next = ST_EVAL;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_scan = 1'b1;
        if (k == last_idx) begin
          state_next = ST_SCAN_END;
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      ST_SCAN_END: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.update = 1'b1;
        k_next     = '0;
        unique case (phase)
          PH_WANT: begin
            if (!sts.hit) begin
              state_next = ST_FINISH;
            end else begin
              cmd.set_one = 1'b1;
              cmd.clr_hit = 1'b1;
              phase_next  = PH_ONE;
              state_next  = ST_SCAN;
            end
          end
          PH_ONE: begin
            j_next     = '0;
            phase_next = PH_CAND;
            state_next = ST_LOAD;
          end
          PH_CAND: begin
            if (j == last_idx) begin
              state_next = ST_FINISH;
            end else begin
              j_next     = j + IDX_W'(1);
              state_next = ST_LOAD;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_LOAD: begin
        cmd.rd_load = 1'b1;
        cmd.clr_hit = 1'b1;
        state_next  = ST_LOAD_WAIT;
      end
      ST_LOAD_WAIT: begin
        k_next     = '0;
        state_next = ST_SCAN;
      end
      ST_FINISH: begin
        if (sts.res_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
          if (sts.found) begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/pffra_dp.sv -----
// datapath: range table, candidate window, overlap check and result register
module pffra_dp
  import pffra_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int IDX_W       = $clog2(MAX_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  pffra_req_t       req_payload,
  input  pffra_cmd_t       cmd,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] wr_addr,
  output pffra_sts_t       sts,
  pffra_stream_if.source   res
);

  logic [UNIT_W-1:0] mem_first [MAX_ENTRIES];
  logic [UNIT_W-1:0] mem_last  [MAX_ENTRIES];
  logic [UNIT_W-1:0] rd_first, rd_last;
  logic              rd_scan_d, rd_load_d;

  logic [LEN_W-1:0]  len_q;
  logic [CAND_W-1:0] lo, hi, pick;
  logic              hit, found;
  logic              out_valid;
  pffra_res_t        out_q;

  logic [WANT_W-1:0] want_fix;
  logic [LEN_W-1:0]  len_fix;
  logic [CAND_W-1:0] pick_end;
  logic              overlap;

  assign want_fix = (req_payload.want_start == '0) ? WANT_W'(1) : req_payload.want_start;
  assign len_fix  = (req_payload.span_length == '0) ? LEN_W'(1) : req_payload.span_length;
  assign pick_end = pick + CAND_W'(len_q) - CAND_W'(1);
  assign overlap  = !((CAND_W'(rd_last) < lo) || (CAND_W'(rd_first) > hi));

  always_ff @(posedge clk) begin
    if (cmd.emit && found) begin
      mem_first[wr_addr] <= pick[UNIT_W-1:0];
      mem_last[wr_addr]  <= pick_end[UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= mem_first[rd_addr];
    rd_last  <= mem_last[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_scan_d <= 1'b0;
      rd_load_d <= 1'b0;
    end else begin
      rd_scan_d <= cmd.rd_scan;
      rd_load_d <= cmd.rd_load;
    end
  end

  // candidate window
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      len_q <= len_fix;
      lo    <= CAND_W'(want_fix);
      hi    <= CAND_W'(want_fix) + CAND_W'(len_fix) - CAND_W'(1);
    end else if (cmd.set_one) begin
      lo <= CAND_W'(1);
      hi <= CAND_W'(len_q);
    end else if (rd_load_d) begin
      lo <= CAND_W'(rd_last) + CAND_W'(1);
      hi <= CAND_W'(rd_last) + CAND_W'(len_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req || cmd.clr_hit) begin
      hit <= 1'b0;
    end else if (rd_scan_d && overlap) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      found <= 1'b0;
    end else if (cmd.update && !hit && (!found || (lo < pick))) begin
      pick  <= lo;
      found <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (found) begin
        out_q.given_start <= pick[UNIT_W-1:0];
        out_q.given_end   <= pick_end[UNIT_W-1:0];
        out_q.rejected    <= 1'b0;
      end else begin
        out_q.given_start <= '0;
        out_q.given_end   <= '0;
        out_q.rejected    <= 1'b1;
      end
    end
  end

  assign res.valid    = out_valid;
  assign res.payload  = out_q;
  assign sts.hit      = hit;
  assign sts.found    = found;
  assign sts.res_free = !out_valid || res.ready;

endmodule

// ----- rtl/preferred_first_fit_range_allocator_top.sv -----
// Preferred first-fit range allocator, top level.
// The req channel carries want_start and span_length; each transaction yields
// exactly one transaction on the res channel with given_start, given_end and
// rejected. A zero start or zero length is taken as 1.
// The preferred range is placed when it overlaps no stored range; otherwise the
// smallest free start among unit 1 and the unit after each stored range wins.
// With n stored ranges, the table is read one entry per cycle through a single
// registered memory read port, and every candidate start takes one full pass of the table.
// One request is in work at a time; req.ready is high only between requests.
// When the table holds MAX_ENTRIES ranges a request is answered without a table scan,
// with rejected set and nothing stored.
// The result sits in an output register; a stalled receiver holds it there,
// and the next request may be taken meanwhile, waiting at its end for the
// register to free up.
// Reset (rst, synchronous) empties the table and drops any pending result.
module preferred_first_fit_range_allocator_top
  import pffra_pkg::*;
#(
  parameter int MAX_ENTRIES = 256
) (
  input  logic           clk,
  input  logic           rst,
  pffra_stream_if.sink   req,
  pffra_stream_if.source res
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  pffra_cmd_t       cmd;
  pffra_sts_t       sts;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             req_ready;

  assign req.ready = req_ready;

  pffra_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .sts       (sts)
  );

  pffra_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_payload (req.payload),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .sts         (sts),
    .res         (res)
  );

endmodule

// ----- tb/preferred_first_fit_range_allocator_top_test.sv -----
// self-checking testbench of the preferred first-fit range allocator top level
`timescale 1ns / 1ps

module preferred_first_fit_range_allocator_top_test;
  import pffra_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int N_RANDOM    = 1880;
  localparam int IDLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 1200;
  localparam bit [63:0] UNIT_MASK = 64'h3_FFFF_FFFF;

  class range_ledger;
    bit [63:0]  range_lo[TABLE_DEPTH];
    bit [63:0]  range_hi[TABLE_DEPTH];
    int         used;
    pffra_res_t due_results[$];
    int         errors;
    int         n_kept;
    int         n_moved;
    int         n_refused;

    function bit span_free(bit [63:0] lo, bit [63:0] hi);
      for (int k = 0; k < used; k++) begin
        if (!(range_hi[k] < lo || range_lo[k] > hi)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void place_request(pffra_req_t r);
      bit [63:0]  want;
      bit [63:0]  len;
      bit [63:0]  pick;
      bit [63:0]  c;
      bit         found;
      pffra_res_t placed;
      placed = '0;
      placed.rejected = 1'b1;
      found = 1'b0;
      pick = '0;
      if (used < TABLE_DEPTH) begin
        want = r.want_start;
        len  = r.span_length;
        if (want == 0) want = 1;
        if (len == 0) len = 1;
        if (span_free(want, want + len - 1)) begin
          pick = want;
          found = 1'b1;
          n_kept++;
        end else begin
          if (span_free(1, len)) begin
            pick = 1;
            found = 1'b1;
          end
          for (int k = 0; k < used; k++) begin
            c = range_hi[k] + 1;
            if (span_free(c, c + len - 1) && (!found || c < pick)) begin
              pick = c;
              found = 1'b1;
            end
          end
          if (found) n_moved++;
        end
        if (found) begin
          range_lo[used] = pick & UNIT_MASK;
          range_hi[used] = (pick + len - 1) & UNIT_MASK;
          placed.given_start = range_lo[used][UNIT_W-1:0];
          placed.given_end   = range_hi[used][UNIT_W-1:0];
          placed.rejected    = 1'b0;
          used++;
        end
      end
      if (placed.rejected) n_refused++;
      due_results.insert(due_results.size(), placed);
    endfunction

    function void match_result(pffra_res_t got);
      pffra_res_t want_r;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unrequested result start %0h end %0h rejected %0b",
                 $time, got.given_start, got.given_end, got.rejected);
        return;
      end
      want_r = due_results.pop_front();
      if (got.given_start !== want_r.given_start) begin
        errors++;
        $display("%0t: given_start expected %0h actual %0h",
                 $time, want_r.given_start, got.given_start);
      end
      if (got.given_end !== want_r.given_end) begin
        errors++;
        $display("%0t: given_end expected %0h actual %0h",
                 $time, want_r.given_end, got.given_end);
      end
      if (got.rejected !== want_r.rejected) begin
        errors++;
        $display("%0t: rejected expected %0b actual %0b",
                 $time, want_r.rejected, got.rejected);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  pffra_stream_if #(.payload_t(pffra_req_t)) req_if ();
  pffra_stream_if #(.payload_t(pffra_res_t)) res_if ();

  preferred_first_fit_range_allocator_top #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if)
  );

  range_ledger ledger = new();
  int          reqs_taken;
  int          results_seen;
  int          idle_cycles;
  int          cycle_count;
  int          burst_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      idle_cycles++;
      if (req_if.valid && req_if.ready) begin
        ledger.place_request(req_if.payload);
        reqs_taken++;
        idle_cycles = 0;
      end
      if (res_if.valid && res_if.ready) begin
        ledger.match_result(res_if.payload);
        results_seen++;
        idle_cycles = 0;
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("preferred_first_fit_range_allocator_top test failed");
        $finish;
      end
    end
  end

  // result receiver with its own stall pattern and one long hold-off
  initial begin
    int mode;
    int left;
    int hold_left;
    bit held_once;
    res_if.ready = 1'b0;
    mode = 0;
    left = 0;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (!held_once && results_seen >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 4) == 0);
          default: res_if.ready <= ((cycle_count % 7) < 4);
        endcase
      end
    end
  end

  task automatic offer(input bit [31:0] w, input bit [24:0] l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.payload <= '{want_start: w, span_length: l};
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (ledger.due_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    bit [31:0] dir_want[16];
    bit [24:0] dir_len[16];
    bit [31:0] rim_want[4];
    bit [24:0] rim_len[4];
    bit [31:0] w;
    bit [24:0] l;
    bit [63:0] lo;
    bit [63:0] hi;
    int        pick;
    int        m;
    int        k;
    dir_want = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'd100, 32'd105, 32'd99, 32'd110, 32'd50,
                 32'h8000_0000, 32'h8000_0005, 32'h0, 32'd7, 32'h7FFF_FFFF,
                 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA};
    dir_len  = '{25'd0, 25'd1, 25'h1FF_FFFF, 25'd10, 25'd3, 25'd1, 25'd5, 25'd60,
                 25'h100_0000, 25'd1, 25'd5, 25'd0, 25'h100_0000,
                 25'd1, 25'h0AA_AAAA, 25'h155_5555};
    rim_want = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000};
    rim_len  = '{25'd0, 25'd1, 25'h1FF_FFFF, 25'h100_0000};
    req_if.valid = 1'b0;
    req_if.payload = '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes, zero start and length, adjacency and relocation
    for (int i = 0; i < 16; i++) offer(dir_want[i], dir_len[i]);
    pause_until_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) pause_until_drained();
      pick = $urandom_range(0, 99);
      m = $urandom_range(0, 99);
      if (m < 60) l = 25'($urandom_range(1, 64));
      else if (m < 90) l = 25'($urandom_range(1, 65536));
      else if (m < 99) l = 25'($urandom_range(1, 1 << 20));
      else l = 25'($urandom);
      w = $urandom;
      if (ledger.used > 0 && pick < 12) begin
        k = $urandom_range(0, ledger.used - 1);
        lo = ledger.range_lo[k];
        hi = ledger.range_hi[k];
        if (pick < 8) begin
          // land inside a stored range
          lo = lo + ($urandom % (hi - lo + 1));
          w = (lo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lo[31:0];
          l = 25'($urandom_range(1, 64));
        end else if (pick < 10 || lo <= l) begin
          w = hi[31:0] + 32'd1;
        end else begin
          w = lo[31:0] - l;
        end
      end else if (pick < 14) begin
        w = rim_want[$urandom_range(0, 3)];
        l = rim_len[$urandom_range(0, 3)];
      end
      offer(w, l);
    end

    req_if.valid <= 1'b0;
    while (ledger.due_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("covered %0d requests: %0d at preferred start, %0d relocated, %0d refused",
             reqs_taken, ledger.n_kept, ledger.n_moved, ledger.n_refused);
    $display("%0d results checked over %0d cycles, table filled to %0d entries",
             results_seen, cycle_count, ledger.used);
    if (ledger.errors == 0 && ledger.due_results.size() == 0) begin
      $display("preferred_first_fit_range_allocator_top test passed");
    end else begin
      $display("preferred_first_fit_range_allocator_top test failed");
    end
    $finish;
  end

endmodule
